[sv/debug_packet_framer_macros.svh]
// assertion macros shared by the framer checker
`ifndef DEBUG_PACKET_FRAMER_MACROS_SVH
`define DEBUG_PACKET_FRAMER_MACROS_SVH

// general clocked property, disabled while reset is low
`define DPF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("framer assertion failed");

// a stalled beat keeps valid high and its payload steady
`define DPF_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
        else $error("framer stalled beat changed");

`endif

[sv/dpf_pkg.sv]
// types, codes and the hex digit function of the debug packet framer
package dpf_pkg;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_RAW   = 2'd1;
    localparam logic [1:0] FUNC_HEX   = 2'd2;
    localparam logic [1:0] FUNC_END   = 2'd3;

    localparam logic [7:0] CHAR_HASH = 8'h23;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
    } t_cmd;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
        logic       overflow;
    } t_beat;

    // upper-case ascii hex digit of one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = 8'h30 + {4'd0, nib};
        end else begin
            ch = 8'h37 + {4'd0, nib};
        end
        return ch;
    endfunction

endpackage

[sv/dpf_if.sv]
// valid/ready stream interfaces for command and character beats
interface dpf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface dpf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;
    logic       overflow;

    modport source (output valid, output out_char, output last, output overflow, input ready);
    modport sink   (input valid, input out_char, input last, input overflow, output ready);
endinterface

[sv/dpf_char_gen.sv]
// character slot generator: one framed character and the next sum and count
module dpf_char_gen
    import dpf_pkg::*;
#(
    parameter int unsigned CNT_W = 11
) (
    input  t_cmd             i_cmd,
    input  logic [1:0]       i_slot,
    input  logic [7:0]       i_sum,
    input  logic [7:0]       i_chk,
    input  logic [CNT_W-1:0] i_count,
    input  logic             i_full,
    output t_beat            o_beat,
    output logic [7:0]       o_sum,
    output logic [CNT_W-1:0] o_count
);

    logic [7:0] ch;
    logic       counted;
    logic       last;

    always_comb begin
        ch      = i_cmd.data_byte;
        counted = 1'b1;
        last    = 1'b1;
        unique case (i_cmd.func)
            FUNC_START: begin
                counted = 1'b0;
            end
            FUNC_RAW: begin
                ch = i_cmd.data_byte;
            end
            FUNC_HEX: begin
                last = (i_slot != 2'd0);
                ch   = hex_char((i_slot == 2'd0) ? i_cmd.data_byte[7:4]
                                                 : i_cmd.data_byte[3:0]);
            end
            FUNC_END: begin
                priority if (i_slot == 2'd0) begin
                    ch   = CHAR_HASH;
                    last = 1'b0;
                end else if (i_slot == 2'd1) begin
                    ch   = hex_char(i_chk[7:4]);
                    last = 1'b0;
                end else begin
                    ch   = hex_char(i_chk[3:0]);
                end
            end
            default: begin
                counted = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_beat.last = last;
        if (!counted) begin
            // marker clears the packet state and is never dropped
            o_beat.out_char = ch;
            o_beat.overflow = 1'b0;
            o_sum           = 8'd0;
            o_count         = '0;
        end else if (i_full) begin
            o_beat.out_char = 8'd0;
            o_beat.overflow = 1'b1;
            o_sum           = i_sum;
            o_count         = i_count;
        end else begin
            o_beat.out_char = ch;
            o_beat.overflow = 1'b0;
            o_sum           = i_sum + ch;
            o_count         = i_count + {{(CNT_W-1){1'b0}}, 1'b1};
        end
    end

endmodule

[sv/debug_packet_framer.sv]
// debug packet framer top level: command register, slot sequencer, output register
//
//  channel   dir  modport  payload
//  i_cmd     in   sink     func[1:0], data_byte[7:0]
//  o_char    out  source   out_char[7:0], last, overflow
//
// one character beat per cycle while o_char does not stall: start and raw make one character, hex two, end three;
// the command register takes the next beat in the cycle the last character
// of the current one is written to the output register
// sum, count and valid flags clear on synchronous active-low reset
// a stall on o_char holds the output register and, through it, the sequencer
module debug_packet_framer
    import dpf_pkg::*;
#(
    parameter int unsigned PACKET_CAPACITY = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dpf_in_if.sink    i_cmd,
    dpf_out_if.source o_char
);

    // count must reach the capacity itself
    localparam int unsigned CNT_W = $clog2(PACKET_CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(PACKET_CAPACITY);

    // command register and slot sequencer
    logic             r_busy;
    t_cmd             r_cmd;
    logic [1:0]       r_slot;

    // packet state; r_chk holds the sum as it stood when an end beat began
    logic [7:0]       r_sum;
    logic [7:0]       r_chk;
    logic [CNT_W-1:0] r_count;

    // output register
    logic             r_out_valid;
    t_beat            r_out;

    t_beat            n_beat;
    logic [7:0]       n_sum;
    logic [CNT_W-1:0] n_count;

    logic             out_free;
    logic             adv;
    logic             fin;
    logic             acc;

    dpf_char_gen #(
        .CNT_W (CNT_W)
    ) u_char_gen (
        .i_cmd   (r_cmd),
        .i_slot  (r_slot),
        .i_sum   (r_sum),
        .i_chk   (r_chk),
        .i_count (r_count),
        .i_full  (r_count == CAP),
        .o_beat  (n_beat),
        .o_sum   (n_sum),
        .o_count (n_count)
    );

    // a slot is produced whenever a command is held and the output register can take it
    assign out_free = !r_out_valid || o_char.ready;
    assign adv      = r_busy && out_free;
    assign fin      = adv && n_beat.last;

    assign i_cmd.ready = !r_busy || fin;
    assign acc         = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_slot      <= 2'd0;
            r_sum       <= 8'd0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_busy <= 1'b1;
                r_slot <= 2'd0;
            end else if (fin) begin
                r_busy <= 1'b0;
            end else if (adv) begin
                r_slot <= r_slot + 2'd1;
            end

            if (adv) begin
                r_sum   <= n_sum;
                r_count <= n_count;
            end

            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_char.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_cmd.func      <= i_cmd.func;
            r_cmd.data_byte <= i_cmd.data_byte;
        end
        // checksum snapshot before the '#' adds to the sum
        if (adv && (r_cmd.func == FUNC_END) && (r_slot == 2'd0)) begin
            r_chk <= r_sum;
        end
        if (adv) begin
            r_out <= n_beat;
        end
    end

    assign o_char.valid    = r_out_valid;
    assign o_char.out_char = r_out.out_char;
    assign o_char.last     = r_out.last;
    assign o_char.overflow = r_out.overflow;

endmodule

[sv/dpf_checker.sv]
// port-level checker for the debug packet framer, bound to the top level
`include "debug_packet_framer_macros.svh"

module dpf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cmd_valid,
    input logic       i_cmd_ready,
    input logic       i_char_valid,
    input logic       i_char_ready,
    input logic [7:0] i_char_data,
    input logic       i_char_last,
    input logic       i_char_ovf
);

    // stalled character beat holds
    `DPF_ASSERT_HOLD(a_char_hold, i_clk, i_rst_n, i_char_valid, i_char_ready, i_char_data)

    // a dropped character always reads as zero
    `DPF_ASSERT(a_ovf_zero, i_clk, i_rst_n, (i_char_valid && i_char_ovf) |-> (i_char_data == 8'd0))

    // an accepted command shows a character beat once it has passed the command register and the output register
    `DPF_ASSERT(a_cmd_out, i_clk, i_rst_n, (i_cmd_valid && i_cmd_ready) |-> ##2 i_char_valid)

    // once a non-final character is taken, the next one follows at once
    `DPF_ASSERT(a_no_gap, i_clk, i_rst_n, (i_char_valid && i_char_ready && !i_char_last) |=> i_char_valid)

endmodule

bind debug_packet_framer dpf_checker u_dpf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cmd_valid  (i_cmd.valid),
    .i_cmd_ready  (i_cmd.ready),
    .i_char_valid (o_char.valid),
    .i_char_ready (o_char.ready),
    .i_char_data  (o_char.out_char),
    .i_char_last  (o_char.last),
    .i_char_ovf   (o_char.overflow)
);
